// ===== sv/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and codes of the distance constraint solver: command and status
// codes, the vertex entry layout and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

  // Command codes carried by one input beat.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_APPLY = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Status codes carried by one result beat.
  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_SHORT  = 2'd1;
  localparam logic [1:0] STATUS_PINNED = 2'd2;
  localparam logic [1:0] STATUS_SAT    = 2'd3;

  // Reset value of the stiffness register (one in Q1.16).
  localparam logic [16:0] STIFF_ONE = 17'h10000;

  // One entry of the vertex memory.
  typedef struct packed {
    logic        pinned;
    logic [31:0] inv_mass;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } vertex_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_LOAD0,
    ST_LOAD1,
    ST_SQUARE,
    ST_ACCUM,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_CHECK,
    ST_DIR_WAIT,
    ST_CORR_MUL,
    ST_CORR_SCALE,
    ST_CORR_STORE,
    ST_RATIO0_WAIT,
    ST_RATIO1_WAIT,
    ST_UPD_MUL,
    ST_UPD_ADD,
    ST_WB0,
    ST_WB1,
    ST_FINISH
  } fsm_state_e;

endpackage

`default_nettype wire

// ===== sv/pbd_vertex_mem.sv =====
// ----------------------------------------------------------------------------
// pbd_vertex_mem
// Vertex table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_vertex_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire  [AW-1:0]        waddr_i,
  input  pbd_pkg::vertex_t     wdata_i,
  input  wire                  re_i,
  input  wire  [AW-1:0]        raddr_i,
  output pbd_pkg::vertex_t     rdata_o
);
  import pbd_pkg::*;

  vertex_t mem_q [DEPTH];
  vertex_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; read data is registered and valid in the cycle after the request.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/pbd_div.sv =====
// ----------------------------------------------------------------------------
// pbd_div
// Restoring divider for (num << FRAC_BITS) / den with num not above den.
// Produces one quotient bit per cycle, FRAC_BITS + 1 bits in all.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire  [32:0]         num_i,
  input  wire  [32:0]         den_i,
  output logic                done_o,
  output logic [FRAC_BITS:0]  quot_o
);
  import pbd_pkg::*;

  localparam int unsigned CW = $clog2(FRAC_BITS + 2);
  localparam logic [CW-1:0] Steps = CW'(FRAC_BITS + 1);

  logic [32:0]        rem_q;
  logic [32:0]        den_q;
  logic               bit_q;
  logic [FRAC_BITS:0] quot_q;
  logic [CW-1:0]      cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [33:0]        trial;
  logic               fits;

  // Trial subtraction of one step.
  always_comb begin
    trial = {rem_q, bit_q};
    fits  = trial >= {1'b0, den_q};
  end

  // Control: busy flag, step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= Steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the high part of the numerator starts as the remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i >> 1;
      bit_q  <= num_i[0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? 33'(trial - {1'b0, den_q}) : trial[32:0];
      bit_q  <= 1'b0;
      quot_q <= {quot_q[FRAC_BITS-1:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== sv/pbd_sqrt.sv =====
// ----------------------------------------------------------------------------
// pbd_sqrt
// Digit-by-digit integer square root of a 66-bit radicand to a 33-bit root,
// one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_sqrt (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  input  wire  [65:0]  rad_i,
  output logic         done_o,
  output logic [32:0]  root_o
);
  import pbd_pkg::*;

  logic [65:0] rad_q;
  logic [35:0] rem_q;
  logic [32:0] root_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [35:0] rem_t;
  logic [35:0] trial;
  logic        fits;

  // Bring down the next bit pair and try the next root bit.
  always_comb begin
    rem_t = {rem_q[33:0], rad_q[65:64]};
    trial = {1'b0, root_q, 2'b01};
    fits  = rem_t >= trial;
  end

  // Control: busy flag, step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd33;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[63:0], 2'b00};
      rem_q  <= fits ? (rem_t - trial) : rem_t;
      root_q <= {root_q[31:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== sv/pbd_distance_constraint_solver_unit.sv =====
// ----------------------------------------------------------------------------
// pbd_distance_constraint_solver_unit
// Position based dynamics distance constraint solver over a vertex memory.
// ----------------------------------------------------------------------------
// A write passes through ST_FINISH, and a read through ST_READ_WAIT and ST_FINISH,
// to the output register. A constraint runs the square root and up to five
// divisions: one per axis and, when both ends are free, one per end mass ratio.
// One item is in work at a time; the next beat is taken while a result waits.
// Reset clears the sequencer and sets stiffness to one; the vertex memory is
// not cleared and its entries are undefined until written.
`default_nettype none

module pbd_distance_constraint_solver_unit #(
  parameter int unsigned VERTEX_COUNT = 4096,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Configuration.
  input  wire                 cfg_we_i,
  input  wire  [16:0]         cfg_wdata_i,
  // Input channel.
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [1:0]          command_i,
  input  wire  [11:0]         first_vertex_i,
  input  wire  [11:0]         second_vertex_i,
  input  wire  signed [31:0]  pos_x_i,
  input  wire  signed [31:0]  pos_y_i,
  input  wire  signed [31:0]  pos_z_i,
  input  wire  [31:0]         inv_mass_i,
  input  wire                 pinned_i,
  input  wire  [31:0]         rest_length_i,
  // Output channel.
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o,
  output logic [1:0]          status_o
);
  import pbd_pkg::*;

  localparam int unsigned AW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int unsigned MA  = 35;
  localparam int unsigned MB  = (FRAC_BITS + 1 > 33) ? FRAC_BITS + 1 : 33;
  localparam int unsigned PW  = MA + MB;
  localparam int unsigned Eps = ((1 << FRAC_BITS) + 5000) / 10000;

  // Wrap a vertex index into the table.
  function automatic logic [AW-1:0] wrap_index(input logic [11:0] v);
    logic [31:0] t;
    t = 32'(v) % VERTEX_COUNT;
    return t[AW-1:0];
  endfunction

  // Sequencer and configuration.
  fsm_state_e state_q, state_d;
  logic [16:0] stiff_q;

  // Item registers.
  logic [AW-1:0]      i0_q, i1_q;
  logic [31:0]        rest_q;
  logic [31:0]        pos0_q [3];
  logic [31:0]        pos1_q [3];
  logic [31:0]        w0_q, w1_q;
  logic               p0_q, p1_q;
  logic [32:0]        dmag_q [3];
  logic               dneg_q [3];
  logic [1:0]         axis_q;
  logic               end_q;
  logic [65:0]        sum_q;
  logic [PW-1:0]      prod_q;
  logic [32:0]        len_q;
  logic [33:0]        cvmag_q;
  logic               cvneg_q;
  logic [FRAC_BITS:0] dir_q;
  logic [34:0]        corr_mag_q [3];
  logic               corr_neg_q [3];
  logic [FRAC_BITS:0] r0_q, r1_q;
  logic               sat_q;

  // Result staging and output register.
  logic [31:0] res_x_q, res_y_q, res_z_q;
  logic [1:0]  res_status_q;
  logic [31:0] out_x_q, out_y_q, out_z_q;
  logic [1:0]  out_status_q;
  logic        out_valid_q;

  // Memory, divider and square root hookup.
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  vertex_t       mem_wdata, mem_rdata;
  logic          div_start, div_done;
  logic [32:0]   div_num, div_den;
  logic [FRAC_BITS:0] div_quot;
  logic          sqrt_start, sqrt_done;
  logic [32:0]   sqrt_root;

  // Shared multiplier operands and derived values.
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [PW-1:0] prod_frac;
  logic [PW-1:0] prod_q16;
  logic [32:0]   wsum;
  logic          in_accept;
  logic          out_free;
  logic [33:0]   cv;
  logic [37:0]   upd_old, upd_dlt, upd_sum;
  logic          upd_neg, upd_moves, upd_hi, upd_lo;
  logic [31:0]   upd_val;

  pbd_vertex_mem #(
    .DEPTH (VERTEX_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pbd_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  pbd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sum_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign wsum       = {1'b0, w0_q} + {1'b0, w1_q};
  assign cv         = {1'b0, len_q} - {2'b00, rest_q};
  assign prod_frac  = prod_q >> FRAC_BITS;
  assign prod_q16   = prod_q >> 16;

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQUARE: begin
        mul_a = MA'(dmag_q[axis_q]);
        mul_b = MB'(dmag_q[axis_q]);
      end
      ST_CORR_MUL: begin
        mul_a = MA'(cvmag_q);
        mul_b = MB'(dir_q);
      end
      ST_CORR_SCALE: begin
        mul_a = MA'(prod_frac[33:0]);
        mul_b = MB'(stiff_q);
      end
      ST_UPD_MUL: begin
        mul_a = corr_mag_q[axis_q];
        mul_b = MB'(end_q ? r1_q : r0_q);
      end
      default: begin
      end
    endcase
  end

  // Coordinate update with saturation.
  always_comb begin
    upd_old   = 38'($signed(end_q ? pos1_q[axis_q] : pos0_q[axis_q]));
    upd_dlt   = {3'b000, prod_frac[34:0]};
    upd_neg   = end_q ? !corr_neg_q[axis_q] : corr_neg_q[axis_q];
    upd_moves = end_q ? !p1_q : !p0_q;
    upd_sum   = upd_neg ? (upd_old - upd_dlt) : (upd_old + upd_dlt);
    upd_hi    = !upd_sum[37] && (upd_sum[36:31] != 6'b000000);
    upd_lo    = upd_sum[37] && (upd_sum[36:31] != 6'b111111);
    if (upd_hi) begin
      upd_val = 32'h7FFF_FFFF;
    end else if (upd_lo) begin
      upd_val = 32'h8000_0000;
    end else begin
      upd_val = upd_sum[31:0];
    end
  end

  // Next state, memory, divider and square root control.
  always_comb begin
    state_d    = state_q;
    mem_we     = 1'b0;
    mem_waddr  = i0_q;
    mem_wdata  = '{pinned: p0_q, inv_mass: w0_q, z: pos0_q[2], y: pos0_q[1], x: pos0_q[0]};
    mem_re     = 1'b0;
    mem_raddr  = wrap_index(first_vertex_i);
    div_start  = 1'b0;
    div_num    = dmag_q[0];
    div_den    = len_q;
    sqrt_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (command_i)
            CMD_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = wrap_index(first_vertex_i);
              mem_wdata = '{pinned: pinned_i, inv_mass: inv_mass_i, z: pos_z_i,
                            y: pos_y_i, x: pos_x_i};
              state_d   = ST_FINISH;
            end
            CMD_READ: begin
              mem_re  = 1'b1;
              state_d = ST_READ_WAIT;
            end
            CMD_APPLY: begin
              mem_re  = 1'b1;
              state_d = ST_LOAD0;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_READ_WAIT: state_d = ST_FINISH;
      ST_LOAD0: begin
        mem_re    = 1'b1;
        mem_raddr = i1_q;
        state_d   = ST_LOAD1;
      end
      ST_LOAD1:  state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ACCUM;
      ST_ACCUM:  state_d = (axis_q == 2'd2) ? ST_SQRT_GO : ST_SQUARE;
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (len_q == 33'd0 || len_q < 33'(Eps)) begin
          state_d = ST_FINISH;
        end else if (p0_q && p1_q) begin
          state_d = ST_FINISH;
        end else if (!p0_q && !p1_q && wsum == 33'd0) begin
          state_d = ST_FINISH;
        end else begin
          div_start = 1'b1;
          div_num   = dmag_q[0];
          state_d   = ST_DIR_WAIT;
        end
      end
      ST_DIR_WAIT: begin
        if (div_done) begin
          state_d = ST_CORR_MUL;
        end
      end
      ST_CORR_MUL:   state_d = ST_CORR_SCALE;
      ST_CORR_SCALE: state_d = ST_CORR_STORE;
      ST_CORR_STORE: begin
        if (axis_q != 2'd2) begin
          div_start = 1'b1;
          div_num   = dmag_q[axis_q + 2'd1];
          state_d   = ST_DIR_WAIT;
        end else if (!p0_q && !p1_q) begin
          div_start = 1'b1;
          div_num   = {1'b0, w0_q};
          div_den   = wsum;
          state_d   = ST_RATIO0_WAIT;
        end else begin
          state_d = ST_UPD_MUL;
        end
      end
      ST_RATIO0_WAIT: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = {1'b0, w1_q};
          div_den   = wsum;
          state_d   = ST_RATIO1_WAIT;
        end
      end
      ST_RATIO1_WAIT: begin
        if (div_done) begin
          state_d = ST_UPD_MUL;
        end
      end
      ST_UPD_MUL: state_d = ST_UPD_ADD;
      ST_UPD_ADD: begin
        if (end_q && axis_q == 2'd2) begin
          state_d = ST_WB0;
        end else begin
          state_d = ST_UPD_MUL;
        end
      end
      ST_WB0: begin
        mem_we  = !p0_q;
        state_d = ST_WB1;
      end
      ST_WB1: begin
        mem_we    = !p1_q;
        mem_waddr = i1_q;
        mem_wdata = '{pinned: p1_q, inv_mass: w1_q, z: pos1_q[2], y: pos1_q[1],
                      x: pos1_q[0]};
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, configuration and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stiff_q     <= STIFF_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        stiff_q <= cfg_wdata_i;
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
      out_z_q      <= res_z_q;
      out_status_q <= res_status_q;
    end
  end

  // Datapath of one item.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        res_x_q      <= '0;
        res_y_q      <= '0;
        res_z_q      <= '0;
        res_status_q <= STATUS_DONE;
        i0_q         <= wrap_index(first_vertex_i);
        i1_q         <= wrap_index(second_vertex_i);
        rest_q       <= rest_length_i;
        sat_q        <= 1'b0;
      end
      ST_READ_WAIT: begin
        res_x_q <= mem_rdata.x;
        res_y_q <= mem_rdata.y;
        res_z_q <= mem_rdata.z;
      end
      ST_LOAD0: begin
        pos0_q[0] <= mem_rdata.x;
        pos0_q[1] <= mem_rdata.y;
        pos0_q[2] <= mem_rdata.z;
        w0_q      <= mem_rdata.inv_mass;
        p0_q      <= mem_rdata.pinned;
      end
      ST_LOAD1: begin
        pos1_q[0] <= mem_rdata.x;
        pos1_q[1] <= mem_rdata.y;
        pos1_q[2] <= mem_rdata.z;
        w1_q      <= mem_rdata.inv_mass;
        p1_q      <= mem_rdata.pinned;
        for (int a = 0; a < 3; a++) begin
          logic [32:0] dd;
          dd = 33'($signed(mem_rdata[32*a +: 32])) - 33'($signed(pos0_q[a]));
          dneg_q[a] <= dd[32];
          dmag_q[a] <= dd[32] ? 33'(-dd) : dd;
        end
        axis_q <= 2'd0;
        sum_q  <= '0;
      end
      ST_ACCUM: begin
        sum_q  <= sum_q + 66'(prod_q);
        axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          len_q <= sqrt_root;
        end
      end
      ST_CHECK: begin
        axis_q  <= 2'd0;
        cvneg_q <= cv[33];
        cvmag_q <= cv[33] ? 34'(-cv) : cv;
        if (len_q == 33'd0 || len_q < 33'(Eps)) begin
          res_status_q <= STATUS_SHORT;
        end else if (p0_q && p1_q) begin
          res_status_q <= STATUS_PINNED;
        end else if (!p0_q && !p1_q && wsum == 33'd0) begin
          res_status_q <= STATUS_PINNED;
        end
      end
      ST_DIR_WAIT: begin
        if (div_done) begin
          dir_q <= div_quot;
        end
      end
      ST_CORR_STORE: begin
        corr_mag_q[axis_q] <= prod_q16[34:0];
        corr_neg_q[axis_q] <= cvneg_q ^ dneg_q[axis_q];
        if (axis_q != 2'd2) begin
          axis_q <= axis_q + 2'd1;
        end else begin
          axis_q <= 2'd0;
          end_q  <= 1'b0;
          r0_q   <= {1'b1, {FRAC_BITS{1'b0}}};
          r1_q   <= {1'b1, {FRAC_BITS{1'b0}}};
        end
      end
      ST_RATIO0_WAIT: begin
        if (div_done) begin
          r0_q <= div_quot;
        end
      end
      ST_RATIO1_WAIT: begin
        if (div_done) begin
          r1_q <= div_quot;
        end
      end
      ST_UPD_ADD: begin
        if (upd_moves) begin
          if (end_q) begin
            pos1_q[axis_q] <= upd_val;
          end else begin
            pos0_q[axis_q] <= upd_val;
          end
          if (upd_hi || upd_lo) begin
            sat_q <= 1'b1;
          end
        end
        end_q <= !end_q;
        if (end_q) begin
          axis_q <= axis_q + 2'd1;
        end
      end
      ST_WB1: begin
        res_status_q <= sat_q ? STATUS_SAT : STATUS_DONE;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = $signed(out_x_q);
  assign out_y_o     = $signed(out_y_q);
  assign out_z_o     = $signed(out_z_q);
  assign status_o    = out_status_q;

endmodule

`default_nettype wire

// ===== verif/tb_pbd_distance_constraint_solver_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pbd_distance_constraint_solver_unit
// Self-checking bench for the distance constraint solver. A directed table of
// vertex writes, reads and constraints opens the run. Random traffic follows
// in four phases, each with its own stiffness and idling pattern. A behavioral
// copy of the vertex table predicts every result beat but those of typed rows,
// which carry their own; a monitor compares each beat with the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pbd_distance_constraint_solver_unit;
  import pbd_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned EPS_Q = 7;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [11:0] v0;
    logic [11:0] v1;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] mass;
    logic        pin;
    logic [31:0] rest;
  } beat_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  status;
  } result_t;

  typedef struct {
    beat_t   beat;
    bit      typed;
    result_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = '0;
  logic [11:0] first_vertex_i = '0;
  logic [11:0] second_vertex_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic [31:0] inv_mass_i = '0;
  logic pinned_i = 1'b0;
  logic [31:0] rest_length_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic [1:0] status_o;

  // Mirror of the vertex table and the stiffness register.
  logic [31:0] vtx_pos [3][4096];
  logic [31:0] vtx_mass [4096];
  logic        vtx_pin [4096];
  bit          vtx_known [4096];
  logic [16:0] stiffness = STIFF_ONE;
  int          live_idx[$];

  result_t pending_results[$];
  row_t    directed[$];
  int      error_count = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  logic    hold_long = 1'b0;

  pbd_distance_constraint_solver_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .command_i, .first_vertex_i, .second_vertex_i, .pos_x_i, .pos_y_i,
    .pos_z_i, .inv_mass_i, .pinned_i, .rest_length_i, .out_valid_o,
    .out_stall_i, .out_x_o, .out_y_o, .out_z_o, .status_o
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Scale by an unsigned fraction, truncating the magnitude toward zero.
  function automatic longint scale_q(longint v, logic [63:0] f);
    logic [63:0] m;
    m = (mag64(v) * f) >> FRAC;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clamp_coord(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic longint coord(int a, int i);
    return longint'($signed(vtx_pos[a][i]));
  endfunction

  // One distance constraint on the mirrored table; returns the status code.
  function automatic logic [1:0] solve_edge(int i0, int i1, logic [31:0] rest);
    longint d[3];
    longint corr[3];
    logic [127:0] sq_sum;
    logic [127:0] t;
    logic [63:0] len, m, dirv, w0, w1, ws, r0, r1;
    longint cv;
    bit sat;
    sq_sum = '0;
    sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      d[a] = coord(a, i1) - coord(a, i0);
      m = mag64(d[a]);
      sq_sum += {64'd0, m} * {64'd0, m};
    end
    // Bitwise floor square root of the squared distance.
    len = '0;
    for (int b = 35; b >= 0; b--) begin
      t = {64'd0, len} | (128'd1 << b);
      if (t * t <= sq_sum) len = t[63:0];
    end
    if (len == 0 || len < EPS_Q) return STATUS_SHORT;
    if (vtx_pin[i0] && vtx_pin[i1]) return STATUS_PINNED;
    cv = longint'(len) - longint'({32'd0, rest});
    for (int a = 0; a < 3; a++) begin
      dirv = (mag64(d[a]) << FRAC) / len;
      m = (mag64(cv) * dirv) >> FRAC;
      m = (m * {47'd0, stiffness}) >> 16;
      corr[a] = ((cv < 0) != (d[a] < 0)) ? -longint'(m) : longint'(m);
    end
    if (!vtx_pin[i0] && !vtx_pin[i1]) begin
      w0 = {32'd0, vtx_mass[i0]};
      w1 = {32'd0, vtx_mass[i1]};
      ws = w0 + w1;
      if (ws == 0) return STATUS_PINNED;
      r0 = (w0 << FRAC) / ws;
      r1 = (w1 << FRAC) / ws;
      for (int a = 0; a < 3; a++) begin
        vtx_pos[a][i0] = clamp_coord(coord(a, i0) + scale_q(corr[a], r0), sat);
        vtx_pos[a][i1] = clamp_coord(coord(a, i1) - scale_q(corr[a], r1), sat);
      end
    end else if (!vtx_pin[i0]) begin
      for (int a = 0; a < 3; a++)
        vtx_pos[a][i0] = clamp_coord(coord(a, i0) + corr[a], sat);
    end else begin
      for (int a = 0; a < 3; a++)
        vtx_pos[a][i1] = clamp_coord(coord(a, i1) - corr[a], sat);
    end
    return sat ? STATUS_SAT : STATUS_DONE;
  endfunction

  function automatic result_t predict_beat(beat_t b);
    result_t r;
    r = '{x: '0, y: '0, z: '0, status: STATUS_DONE};
    case (b.cmd)
      CMD_WRITE: begin
        vtx_pos[0][b.v0] = b.x;
        vtx_pos[1][b.v0] = b.y;
        vtx_pos[2][b.v0] = b.z;
        vtx_mass[b.v0] = b.mass;
        vtx_pin[b.v0] = b.pin;
        if (!vtx_known[b.v0]) live_idx = {live_idx, int'(b.v0)};
        vtx_known[b.v0] = 1'b1;
      end
      CMD_APPLY: r.status = solve_edge(b.v0, b.v1, b.rest);
      CMD_READ: begin
        r.x = vtx_pos[0][b.v0];
        r.y = vtx_pos[1][b.v0];
        r.z = vtx_pos[2][b.v0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic beat_t mk_beat(logic [1:0] cmd, logic [11:0] v0, logic [11:0] v1,
                                    logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    logic [31:0] mass, logic pin, logic [31:0] rest);
    beat_t b;
    b = '{cmd: cmd, v0: v0, v1: v1, x: x, y: y, z: z, mass: mass, pin: pin, rest: rest};
    return b;
  endfunction

  function automatic void add_row(beat_t b, bit typed, logic [1:0] st,
                                  logic [31:0] x = '0);
    row_t r;
    r.beat = b;
    r.typed = typed;
    r.res = '{x: x, y: '0, z: '0, status: st};
    directed = {directed, r};
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  function automatic logic [31:0] rand_wide(int unsigned lim);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, lim);
  endfunction

  function automatic logic [11:0] pick_live();
    return 12'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
  endfunction

  // Mostly constraints between written vertices, with writes and reads mixed in.
  function automatic beat_t rand_beat();
    beat_t b;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    b = mk_beat(CMD_APPLY, pick_live(), pick_live(), $urandom, $urandom, $urandom,
                $urandom, 1'($urandom_range(0, 1)), rand_wide(32'h0020_0000));
    if ($urandom_range(0, 15) == 0) b.v1 = b.v0;
    if (sel < 22) begin
      b.cmd = CMD_WRITE;
      b.v0 = ($urandom_range(0, 2) == 0) ? 12'($urandom) : pick_live();
      b.x = rand_coord();
      b.y = rand_coord();
      b.z = rand_coord();
      b.mass = rand_wide(32'h0004_0000);
      b.pin = ($urandom_range(0, 3) == 0);
    end else if (sel < 40) begin
      b.cmd = CMD_READ;
    end else if (sel < 42) begin
      b.cmd = CMD_UNUSED;
      b.v0 = 12'($urandom);
    end
    return b;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, want, got);
    error_count++;
  endtask

  // Offer one beat, wait for its acceptance, then idle at random.
  task automatic send_beat(beat_t b, bit typed, result_t want);
    result_t pred;
    in_valid_i <= 1'b1;
    command_i <= b.cmd;
    first_vertex_i <= b.v0;
    second_vertex_i <= b.v1;
    pos_x_i <= b.x;
    pos_y_i <= b.y;
    pos_z_i <= b.z;
    inv_mass_i <= b.mass;
    pinned_i <= b.pin;
    rest_length_i <= b.rest;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_beat(b);
    if (typed) pred = want;
    pending_results = {pending_results, pred};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_stiffness(logic [16:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stiffness = v;
    @(posedge clk_i);
  endtask

  // Receiver stall, with an optional long hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= hold_long || ($urandom_range(0, 99) < stall_pct);
  end

  // Result monitor.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] result beat with nothing expected", $realtime);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_x_o !== want.x) report_mismatch("out_x", want.x, out_x_o);
        if (out_y_o !== want.y) report_mismatch("out_y", want.y, out_y_o);
        if (out_z_o !== want.z) report_mismatch("out_z", want.z, out_z_o);
        if (status_o !== want.status) report_mismatch("status", want.status, status_o);
      end
    end
  end

  initial begin
    result_t none;
    none = '{x: '0, y: '0, z: '0, status: STATUS_DONE};

    // Directed table: writes, reads and every constraint outcome.
    add_row(mk_beat(CMD_WRITE, 12'd0, 12'd0, 0, 0, 0, ONE_Q, 0, 0), 1, STATUS_DONE);
    add_row(mk_beat(CMD_WRITE, 12'd4095, 12'd0, 3 * ONE_Q, 0, 0, ONE_Q, 0, 0),
            1, STATUS_DONE);
    add_row(mk_beat(CMD_READ, 12'd4095, 12'd0, 0, 0, 0, 0, 0, 0), 1, STATUS_DONE,
            3 * ONE_Q);
    // Distance already at rest length.
    add_row(mk_beat(CMD_APPLY, 12'd0, 12'd4095, 0, 0, 0, 0, 0, 3 * ONE_Q), 1, STATUS_DONE);
    // Two equal ends.
    add_row(mk_beat(CMD_APPLY, 12'd0, 12'd0, 0, 0, 0, 0, 0, 0), 1, STATUS_SHORT);
    add_row(mk_beat(CMD_WRITE, 12'd1, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                    32'hFFFF_FFFF, 1, 0), 0, STATUS_DONE);
    add_row(mk_beat(CMD_WRITE, 12'd2, 12'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 0, 1, 0), 0, STATUS_DONE);
    // Both ends pinned.
    add_row(mk_beat(CMD_APPLY, 12'd1, 12'd2, 0, 0, 0, 0, 0, 0), 1, STATUS_PINNED);
    add_row(mk_beat(CMD_WRITE, 12'd3, 12'd0, 0, 0, 0, 0, 0, 0), 0, STATUS_DONE);
    add_row(mk_beat(CMD_WRITE, 12'd5, 12'd0, ONE_Q, 0, 0, 0, 0, 0), 0, STATUS_DONE);
    // Two free ends without mass.
    add_row(mk_beat(CMD_APPLY, 12'd3, 12'd5, 0, 0, 0, 0, 0, 0), 1, STATUS_PINNED);
    add_row(mk_beat(CMD_APPLY, 12'd0, 12'd4095, 0, 0, 0, 0, 0, ONE_Q), 0, STATUS_DONE);
    add_row(mk_beat(CMD_APPLY, 12'd1, 12'd3, 0, 0, 0, 0, 0, 0), 0, STATUS_DONE);
    add_row(mk_beat(CMD_APPLY, 12'd3, 12'd1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 0, STATUS_DONE);
    add_row(mk_beat(CMD_WRITE, 12'd6, 12'd0, 5, 0, 0, ONE_Q, 0, 0), 0, STATUS_DONE);
    add_row(mk_beat(CMD_WRITE, 12'd7, 12'd0, 0, 0, 0, ONE_Q, 0, 0), 0, STATUS_DONE);
    // Distance under epsilon.
    add_row(mk_beat(CMD_APPLY, 12'd7, 12'd6, 0, 0, 0, 0, 0, 0), 1, STATUS_SHORT);
    add_row(mk_beat(CMD_WRITE, 12'd8, 12'd0, 32'h7FFF_0000, 0, 0, ONE_Q, 0, 0),
            0, STATUS_DONE);
    add_row(mk_beat(CMD_WRITE, 12'd9, 12'd0, 32'h7FFE_0000, 0, 0, ONE_Q, 1, 0),
            0, STATUS_DONE);
    // Pinned first end pushes the free end past the top of the range.
    add_row(mk_beat(CMD_APPLY, 12'd9, 12'd8, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, STATUS_SAT);
    add_row(mk_beat(CMD_READ, 12'd8, 12'd0, 0, 0, 0, 0, 0, 0), 1, STATUS_DONE,
            32'h7FFF_FFFF);
    add_row(mk_beat(CMD_UNUSED, 12'd8, 12'd9, 0, 0, 0, 0, 0, 0), 1, STATUS_DONE);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_beat(directed[i].beat, directed[i].typed, directed[i].res);
    drain();

    // Random phases, each with its own stiffness and idling pattern.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  write_stiffness(17'd0); end
        1: begin send_idle_pct = 82; stall_pct = 0;  write_stiffness(17'h1FFFF); end
        2: begin send_idle_pct = 0;  stall_pct = 82; write_stiffness(17'($urandom)); end
        default: begin
          send_idle_pct = 29;
          stall_pct = 29;
          write_stiffness(STIFF_ONE);
        end
      endcase
      if (p == 0) begin
        fork
          begin
            repeat (30) @(posedge clk_i);
            hold_long <= 1'b1;
            repeat (800) @(posedge clk_i);
            hold_long <= 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 100; n++) send_beat(rand_beat(), 0, none);
      drain();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pbd_pkg.sv
sv/pbd_vertex_mem.sv
sv/pbd_div.sv
sv/pbd_sqrt.sv
sv/pbd_distance_constraint_solver_unit.sv
verif/tb_pbd_distance_constraint_solver_unit.sv
